// ===== rtl/ffw_pkg.sv =====
package ffw_pkg;

	localparam int TABLE_SIZE_DEF = 1024;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_TCP      = 8'd6;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] LEN_L4_MIN     = 16'd42;

	localparam logic       REG_OUTSIDE_PORT   = 1'b0;
	localparam logic       REG_PROTECTED_PORT = 1'b1;
	localparam logic [7:0] OUTSIDE_PORT_RST   = 8'd0;
	localparam logic [7:0] PROTECTED_PORT_RST = 8'd1;

	localparam int KEY_W = 104;

	typedef struct packed {
		logic [7:0]  ingress_port;
		logic [15:0] frame_length;
		logic [15:0] ether_type;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_l4_port;
		logic [15:0] dest_l4_port;
	} in_word_t;

	typedef struct packed {
		logic       verdict;
		logic [7:0] redirect_port;
		logic       flow_learned;
		logic       table_full_drop;
	} out_word_t;

	typedef struct packed {
		logic [7:0]  proto;
		logic [31:0] addr_lo;
		logic [31:0] addr_hi;
		logic [15:0] l4_lo;
		logic [15:0] l4_hi;
	} flow_key_t;

	typedef struct packed {
		logic       valid;
		flow_key_t  key;
		logic [7:0] return_port;
	} entry_t;

	typedef struct packed {
		logic [7:0] outside_port;
		logic [7:0] protected_port;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK
	} state_t;

endpackage

// ===== rtl/ffw_table.sv =====
module ffw_table
	import ffw_pkg::*;
#(
	parameter int DEPTH = TABLE_SIZE_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data
);

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/ffw_cfg.sv =====
module ffw_cfg
	import ffw_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outside_port   <= OUTSIDE_PORT_RST;
			cfg_q.protected_port <= PROTECTED_PORT_RST;
		end else if (wr) begin
			if (paddr[2] == REG_OUTSIDE_PORT) begin
				cfg_q.outside_port <= pwdata[7:0];
			end else begin
				cfg_q.protected_port <= pwdata[7:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_OUTSIDE_PORT) begin
			prdata = {24'd0, cfg_q.outside_port};
		end else begin
			prdata = {24'd0, cfg_q.protected_port};
		end
	end

endmodule

// ===== rtl/stateful_flow_firewall_top.sv =====
// Flow firewall: one header word per start, one result word on done, which
// the receiver cannot hold off. Headers that are short, not IPv4 or not
// TCP/UDP give their result in the cycle after start. Others probe the flow
// table linearly from a hashed slot, one entry per cycle through the single
// read port, P entries in all (1 for an empty or matching home slot, up to
// TABLE_SIZE on a full table). After reset a clearing pass writes every
// table entry invalid with busy high.
module stateful_flow_firewall_top
	import ffw_pkg::*;
#(
	parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_word_t    in_word,
	output logic        done,
	output out_word_t   out_word,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = $clog2(TABLE_SIZE);
	localparam int CW = $clog2(TABLE_SIZE + 1);
	localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SIZE - 1);
	localparam logic [AW:0]   SIZE_X    = (AW+1)'(TABLE_SIZE);
	localparam logic [CW-1:0] SIZE_C    = CW'(TABLE_SIZE);

	cfg_t cfg;

	state_t         state_q, state_d;
	flow_key_t      key_q;
	logic           prot_q;
	logic [AW-1:0]  addr_q;
	logic [AW-1:0]  probe_q;
	logic [CW-1:0]  count_q;
	logic           done_q;
	out_word_t      out_q;

	flow_key_t      key_c;
	logic           eligible;
	logic [AW-1:0]  fold;
	logic [AW:0]    fold_x;
	logic [AW-1:0]  home;
	logic [AW-1:0]  next_addr;

	entry_t         rd_data;
	logic [AW-1:0]  rd_addr;
	logic           wr_en;
	entry_t         wr_data;

	logic           hit;
	logic           empty;
	logic           last;
	logic           decide;
	logic           accept;

	ffw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ffw_table #(.DEPTH(TABLE_SIZE)) u_table (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (addr_q),
		.wr_data (wr_data)
	);

	assign accept = start && !busy;

	always_comb begin
		eligible = (in_word.frame_length >= LEN_L4_MIN)
			&& (in_word.ether_type == ETHERTYPE_IPV4)
			&& ((in_word.ip_protocol == PROTO_TCP) || (in_word.ip_protocol == PROTO_UDP));
		key_c.proto = in_word.ip_protocol;
		if (in_word.source_address <= in_word.dest_address) begin
			key_c.addr_lo = in_word.source_address;
			key_c.addr_hi = in_word.dest_address;
		end else begin
			key_c.addr_lo = in_word.dest_address;
			key_c.addr_hi = in_word.source_address;
		end
		if (in_word.source_l4_port <= in_word.dest_l4_port) begin
			key_c.l4_lo = in_word.source_l4_port;
			key_c.l4_hi = in_word.dest_l4_port;
		end else begin
			key_c.l4_lo = in_word.dest_l4_port;
			key_c.l4_hi = in_word.source_l4_port;
		end
	end

	always_comb begin
		fold = '0;
		for (int i = 0; i < KEY_W; i++) begin
			fold[i % AW] = fold[i % AW] ^ key_c[i];
		end
		fold_x = {1'b0, fold};
		if (fold_x >= SIZE_X) begin
			fold_x = fold_x - SIZE_X;
		end
		home = fold_x[AW-1:0];
	end

	assign next_addr = (addr_q == LAST_ADDR) ? '0 : addr_q + 1'b1;

	assign hit    = rd_data.valid && (rd_data.key == key_q);
	assign empty  = !rd_data.valid;
	assign last   = (probe_q == LAST_ADDR);
	assign decide = hit || empty || last;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start && eligible) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (decide) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		busy    = 1'b1;
		rd_addr = addr_q;
		wr_en   = 1'b0;
		wr_data = '0;
		unique case (state_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
			end
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_READ: begin
			end
			ST_CHECK: begin
				if (!decide) begin
					rd_addr = next_addr;
				end
				if (!prot_q && empty) begin
					wr_en               = 1'b1;
					wr_data.valid       = 1'b1;
					wr_data.key         = key_q;
					wr_data.return_port = cfg.outside_port;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			probe_q <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					addr_q <= next_addr;
				end
				ST_IDLE: begin
					if (start) begin
						done_q  <= !eligible;
						addr_q  <= home;
						probe_q <= '0;
					end
				end
				ST_READ: begin
				end
				ST_CHECK: begin
					if (decide) begin
						done_q <= 1'b1;
						if (!prot_q && empty) begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						addr_q  <= next_addr;
						probe_q <= probe_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key_c;
			prot_q <= (in_word.ingress_port == cfg.protected_port);
			out_q  <= '0;
		end else if (state_q == ST_CHECK && decide) begin
			if (prot_q) begin
				out_q.verdict         <= hit;
				out_q.redirect_port   <= hit ? rd_data.return_port : 8'd0;
				out_q.flow_learned    <= 1'b0;
				out_q.table_full_drop <= 1'b0;
			end else begin
				out_q.verdict         <= 1'b1;
				out_q.redirect_port   <= cfg.protected_port;
				out_q.flow_learned    <= empty;
				out_q.table_full_drop <= !hit && !empty;
			end
		end
	end

	assign done     = done_q;
	assign out_word = out_q;

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_CHECK))
		else $error("result without a finished lookup");

	a_learn_xor_drop: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(out_q.flow_learned && out_q.table_full_drop))
		else $error("flow learned and dropped together");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= SIZE_C)
		else $error("flow count above table size");

	a_learn_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && out_q.flow_learned) |-> (count_q == $past(count_q) + 1'b1))
		else $error("learned flow not counted");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && out_q.table_full_drop) |-> (count_q == SIZE_C))
		else $error("drop with room in table");

endmodule
